// ===== hdl/npem_pkg.sv =====
// ----------------------------------------------------------------------------
// npem_pkg: shared types and constants for the nearest polyline edge match
// Operation codes, field widths and the controller/datapath command bundle.
// ----------------------------------------------------------------------------
`default_nettype none
package npem_pkg;

    localparam int COORD_W          = 32;
    localparam int LEN_W            = 32;
    localparam int DEF_FRAC_BITS    = 16;
    localparam int DEF_ID_BITS      = 16;
    localparam int ID_PORT_W        = 16;
    localparam int T_FRAC           = 30;
    localparam int T_W              = T_FRAC + 1;
    localparam int WIDE_W           = 68;

    typedef enum logic [1:0] {
        OP_QUERY  = 2'd0,
        OP_VERTEX = 2'd1,
        OP_FINISH = 2'd2,
        OP_NONE   = 2'd3
    } op_t;

    // commands from the controller to the datapath
    typedef struct packed {
        logic load_query;   // op 0: clear search, store point
        logic load_edge;    // first vertex of edge
        logic load_vertex;  // store prev vertex
        logic seg_start;    // compute vectors from prev and new vertex
        logic div_start;    // start t division
        logic div_step;
        logic proj;         // compute projected point offsets
        logic dist_prep;    // form projected point
        logic sqrt_start;
        logic sqrt_step;
        logic sqrt_to_dist; // store root as distance
        logic sqrt_to_seg;  // store root as segment length
        logic along_mul;
        logic commit;       // compare and keep best, advance running sum
    } npem_cmd_t;

    typedef struct packed {
        logic seg_skip_div; // t settled without division
    } npem_stat_t;

endpackage
`default_nettype wire

// ===== hdl/npem_if.sv =====
// ----------------------------------------------------------------------------
// npem_in_if / npem_out_if: valid/ready channels of the edge matcher
// Request channel carries one stream item, result channel one match result.
// ----------------------------------------------------------------------------
`default_nettype none
interface npem_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  operation;
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic        new_edge;
    logic        edge_enabled;
    logic [15:0] edge_ident;
    logic [15:0] from_node;
    logic [15:0] to_node;
    logic [31:0] total_length;
    modport source (output valid, operation, x, y, new_edge, edge_enabled, edge_ident,
                    from_node, to_node, total_length, input ready);
    modport sink (input valid, operation, x, y, new_edge, edge_enabled, edge_ident,
                  from_node, to_node, total_length, output ready);
endinterface

interface npem_out_if;
    logic        valid;
    logic        ready;
    logic        found;
    logic [15:0] match_edge;
    logic [15:0] match_from;
    logic [15:0] match_to;
    logic signed [31:0] proj_x;
    logic signed [31:0] proj_y;
    logic [31:0] match_distance;
    logic [31:0] along_edge;
    logic [31:0] match_length;
    modport source (output valid, found, match_edge, match_from, match_to, proj_x, proj_y,
                    match_distance, along_edge, match_length, input ready);
    modport sink (input valid, found, match_edge, match_from, match_to, proj_x, proj_y,
                  match_distance, along_edge, match_length, output ready);
endinterface
`default_nettype wire

// ===== hdl/nearest_polyline_edge_match_top.sv =====
// ----------------------------------------------------------------------------
// nearest_polyline_edge_match_top: nearest segment projection on edge polylines
//
//   channel   dir  contents
//   req       in   operation, x, y, new_edge, edge data
//   res       out  found, ids, projection, distance, along, length
//   cfg       in   cfg_we / cfg_data: max_distance
//
// Query, first-vertex and finish requests complete without leaving idle. A
// segment of an enabled edge runs 30 divider steps for t and two 34-step square
// roots through the shared root unit before the next ready; the divider steps
// are skipped when t settles without division.
// Reset clears the search state; max_distance resets to all ones.
// A held result blocks further requests until it is taken.
// ----------------------------------------------------------------------------
`default_nettype none
module nearest_polyline_edge_match_top #(
    parameter int COORD_FRAC_BITS = npem_pkg::DEF_FRAC_BITS,
    parameter int ID_BITS         = npem_pkg::DEF_ID_BITS
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    npem_in_if.sink          req,
    npem_out_if.source       res,
    input  wire logic        cfg_we,
    input  wire logic [31:0] cfg_data
);
    import npem_pkg::*;

    npem_cmd_t  cmd;
    npem_stat_t stat;
    logic emit, out_valid_reg, ok;
    logic [31:0] max_dist_reg;
    logic        bvalid;
    logic [31:0] bdist, balong, blen;
    logic [ID_BITS-1:0] bedge, bfrom, bto;
    logic signed [31:0] bpx, bpy;

    npem_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n), .in_valid(req.valid), .in_ready(req.ready),
        .operation(req.operation), .new_edge(req.new_edge),
        .edge_enabled(req.edge_enabled), .cmd(cmd), .stat(stat), .emit(emit),
        .out_busy(out_valid_reg)
    );

    npem_datapath #(.FRAC_BITS(COORD_FRAC_BITS), .ID_BITS(ID_BITS)) u_dp (
        .clk(clk), .rst_n(rst_n), .cmd(cmd), .stat(stat), .x(req.x), .y(req.y),
        .edge_ident(req.edge_ident), .from_node(req.from_node), .to_node(req.to_node),
        .total_length(req.total_length), .best_valid(bvalid), .best_distance(bdist),
        .best_edge(bedge), .best_from(bfrom), .best_to(bto), .best_px(bpx),
        .best_py(bpy), .best_along(balong), .best_length(blen)
    );

    assign ok = bvalid && (bdist <= max_dist_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_dist_reg <= '1;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we) max_dist_reg <= cfg_data;
            if (emit) out_valid_reg <= 1'b1;
            else if (res.ready) out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            res.found <= ok;
            res.match_edge <= ok ? 16'(bedge) : 16'd0;
            res.match_from <= ok ? 16'(bfrom) : 16'd0;
            res.match_to <= ok ? 16'(bto) : 16'd0;
            res.proj_x <= ok ? bpx : 32'sd0;
            res.proj_y <= ok ? bpy : 32'sd0;
            res.match_distance <= ok ? bdist : 32'd0;
            res.along_edge <= ok ? balong : 32'd0;
            res.match_length <= ok ? blen : 32'd0;
        end
    end

    assign res.valid = out_valid_reg;

    assert property (@(posedge clk) disable iff (!rst_n) emit |-> !out_valid_reg)
        else $error("result overwritten");
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !res.ready |=> out_valid_reg)
        else $error("result dropped");
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> !req.ready)
        else $error("request taken with result pending");

endmodule
`default_nettype wire

// ===== hdl/npem_datapath.sv =====
// ----------------------------------------------------------------------------
// npem_datapath: segment projection arithmetic and best-match storage
// Restoring divider for t and shared bit-serial square root for lengths.
// ----------------------------------------------------------------------------
`default_nettype none
module npem_datapath #(
    parameter int FRAC_BITS = npem_pkg::DEF_FRAC_BITS,
    parameter int ID_BITS   = npem_pkg::DEF_ID_BITS
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire npem_pkg::npem_cmd_t cmd,
    output npem_pkg::npem_stat_t     stat,
    input  wire logic signed [31:0]  x,
    input  wire logic signed [31:0]  y,
    input  wire logic [15:0]         edge_ident,
    input  wire logic [15:0]         from_node,
    input  wire logic [15:0]         to_node,
    input  wire logic [31:0]         total_length,
    output logic                     best_valid,
    output logic [31:0]              best_distance,
    output logic [ID_BITS-1:0]       best_edge,
    output logic [ID_BITS-1:0]       best_from,
    output logic [ID_BITS-1:0]       best_to,
    output logic signed [31:0]       best_px,
    output logic signed [31:0]       best_py,
    output logic [31:0]              best_along,
    output logic [31:0]              best_length
);
    import npem_pkg::*;

    localparam logic [67:0] THR = 68'((64'd1 << (2 * FRAC_BITS)) / 64'd1000000000000);

    logic signed [31:0] qx_reg, qy_reg, ax_reg, ay_reg;
    logic [ID_BITS-1:0] cid_reg, cfrom_reg, cto_reg;
    logic [31:0] clen_reg, run_reg;
    logic signed [32:0] vx_reg, vy_reg, wx_reg, wy_reg;
    logic [67:0] vv_reg, dot_reg, rem_reg;
    logic [T_W-1:0] t_reg;
    logic signed [32:0] ox_reg, oy_reg;
    logic signed [33:0] px_reg, py_reg;
    logic [67:0] rad_reg;
    logic [33:0] root_reg;
    logic [5:0]  bit_reg;
    logic [31:0] dist_reg, seg_reg;
    logic [63:0] along_p_reg;

    logic [32:0] mvx, mvy, mwx, mwy;
    logic [65:0] sqx, sqy, pxp, pyp;
    logic [67:0] pos, neg;
    logic [67:0] rem_sh;
    logic [33:0] dxm, dym;
    logic [67:0] trial;
    logic [33:0] cand;
    logic [31:0] root_sat;
    logic [63:0] offx, offy;
    logic [32:0] along_sum, run_sum;

    function automatic logic [32:0] mag33(input logic signed [32:0] v);
        return v[32] ? 33'(-v) : 33'(v);
    endfunction
    function automatic logic [33:0] mag34(input logic signed [33:0] v);
        return v[33] ? 34'(-v) : 34'(v);
    endfunction

    always_comb
    begin
        mvx = mag33(vx_reg);
        mvy = mag33(vy_reg);
        mwx = mag33(wx_reg);
        mwy = mag33(wy_reg);
        sqx = 66'(mvx) * 66'(mvx);
        sqy = 66'(mvy) * 66'(mvy);
        pxp = 66'(mwx) * 66'(mvx);
        pyp = 66'(mwy) * 66'(mvy);
        pos = 68'd0;
        neg = 68'd0;
        if (wx_reg[32] != vx_reg[32]) neg = neg + 68'(pxp); else pos = pos + 68'(pxp);
        if (wy_reg[32] != vy_reg[32]) neg = neg + 68'(pyp); else pos = pos + 68'(pyp);
        rem_sh = {rem_reg[66:0], 1'b0};
        cand = root_reg | (34'd1 << bit_reg);
        trial = 68'(cand) * 68'(cand);
        root_sat = (root_reg > 34'hFFFF_FFFF) ? 32'hFFFF_FFFF : root_reg[31:0];
        offx = 64'(t_reg) * 64'(mvx);
        offy = 64'(t_reg) * 64'(mvy);
        dxm = mag34(px_reg - 34'(qx_reg));
        dym = mag34(py_reg - 34'(qy_reg));
        along_sum = 33'(run_reg) + 33'(along_p_reg >> T_FRAC);
        run_sum = 33'(run_reg) + 33'(seg_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            best_valid    <= 1'b0;
            best_distance <= '1;
            best_edge     <= '0;
            best_from     <= '0;
            best_to       <= '0;
            best_px       <= '0;
            best_py       <= '0;
            best_along    <= '0;
            best_length   <= '0;
            qx_reg        <= '0;
            qy_reg        <= '0;
            ax_reg        <= '0;
            ay_reg        <= '0;
            cid_reg       <= '0;
            cfrom_reg     <= '0;
            cto_reg       <= '0;
            clen_reg      <= '0;
            run_reg       <= '0;
        end
        else
        begin
            if (cmd.load_query)
            begin
                qx_reg <= x;
                qy_reg <= y;
                cid_reg <= '0;
                cfrom_reg <= '0;
                cto_reg <= '0;
                clen_reg <= '0;
                run_reg <= '0;
                best_valid <= 1'b0;
                best_distance <= '1;
                best_edge <= '0;
                best_from <= '0;
                best_to <= '0;
                best_px <= '0;
                best_py <= '0;
                best_along <= '0;
                best_length <= '0;
            end
            if (cmd.load_edge)
            begin
                cid_reg <= ID_BITS'(edge_ident);
                cfrom_reg <= ID_BITS'(from_node);
                cto_reg <= ID_BITS'(to_node);
                clen_reg <= total_length;
                run_reg <= '0;
            end
            if (cmd.load_vertex)
            begin
                ax_reg <= x;
                ay_reg <= y;
            end
            if (cmd.commit)
            begin
                if (!best_valid || dist_reg < best_distance)
                begin
                    best_valid <= 1'b1;
                    best_distance <= dist_reg;
                    best_edge <= cid_reg;
                    best_from <= cfrom_reg;
                    best_to <= cto_reg;
                    best_px <= px_reg[31:0];
                    best_py <= py_reg[31:0];
                    best_along <= along_sum[32] ? 32'hFFFF_FFFF : along_sum[31:0];
                    best_length <= clen_reg;
                end
                run_reg <= run_sum[32] ? 32'hFFFF_FFFF : run_sum[31:0];
                // advance the start vertex to the segment end: a + v
                ax_reg <= ax_reg + $signed(vx_reg[31:0]);
                ay_reg <= ay_reg + $signed(vy_reg[31:0]);
            end
        end
    end

    // arithmetic working registers
    always_ff @(posedge clk)
    begin
        if (cmd.seg_start)
        begin
            vx_reg <= 33'(x) - 33'(ax_reg);
            vy_reg <= 33'(y) - 33'(ay_reg);
            wx_reg <= 33'(qx_reg) - 33'(ax_reg);
            wy_reg <= 33'(qy_reg) - 33'(ay_reg);
        end
        if (cmd.div_start)
        begin
            vv_reg <= 68'(sqx) + 68'(sqy);
            dot_reg <= pos - neg;
            rem_reg <= pos - neg;
            if (!((68'(sqx) + 68'(sqy)) > THR && pos > neg))
                t_reg <= '0;
            else if ((pos - neg) >= (68'(sqx) + 68'(sqy)))
                t_reg <= T_W'(1) << T_FRAC;
            else
                t_reg <= '0;
        end
        if (cmd.div_step)
        begin
            if (rem_sh >= vv_reg)
            begin
                rem_reg <= rem_sh - vv_reg;
                t_reg <= {t_reg[T_W-2:0], 1'b1};
            end
            else
            begin
                rem_reg <= rem_sh;
                t_reg <= {t_reg[T_W-2:0], 1'b0};
            end
        end
        if (cmd.proj)
        begin
            ox_reg <= vx_reg[32] ? -33'(offx >> T_FRAC) : 33'(offx >> T_FRAC);
            oy_reg <= vy_reg[32] ? -33'(offy >> T_FRAC) : 33'(offy >> T_FRAC);
        end
        if (cmd.dist_prep)
        begin
            px_reg <= 34'(ax_reg) + 34'(ox_reg);
            py_reg <= 34'(ay_reg) + 34'(oy_reg);
        end
        if (cmd.sqrt_start)
        begin
            // distance radicand first, segment second
            if (cmd.dist_prep)
                rad_reg <= '0;
            else if (cmd.sqrt_to_dist)
                rad_reg <= vv_reg;
            else
                rad_reg <= 68'(dxm) * 68'(dxm) + 68'(dym) * 68'(dym);
            root_reg <= '0;
            bit_reg <= 6'd33;
        end
        if (cmd.sqrt_step)
        begin
            if (trial <= rad_reg)
                root_reg <= cand;
            bit_reg <= bit_reg - 6'd1;
        end
        if (cmd.sqrt_to_dist)
            dist_reg <= root_sat;
        if (cmd.sqrt_to_seg)
            seg_reg <= root_sat;
        if (cmd.along_mul)
            along_p_reg <= 64'(t_reg) * 64'(seg_reg);
    end

    assign stat.seg_skip_div = !(vv_reg > THR && dot_reg > 68'd0 && dot_reg < vv_reg);

endmodule
`default_nettype wire

// ===== hdl/npem_ctrl.sv =====
// ----------------------------------------------------------------------------
// npem_ctrl: sequencer for the edge matcher
// Decodes requests, steps the datapath through one segment, drives results.
// ----------------------------------------------------------------------------
`default_nettype none
module npem_ctrl (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 in_valid,
    output logic                      in_ready,
    input  wire logic [1:0]           operation,
    input  wire logic                 new_edge,
    input  wire logic                 edge_enabled,
    output npem_pkg::npem_cmd_t       cmd,
    input  wire npem_pkg::npem_stat_t stat,
    output logic                      emit,
    input  wire logic                 out_busy
);
    import npem_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE, S_VEC, S_DIVSET, S_DIV, S_PROJ, S_PX, S_SQD, S_SQDRUN,
        S_SQS, S_SQSRUN, S_ALONG, S_ALMUL, S_COMMIT
    } state_t;

    state_t state_reg;
    logic [5:0] cnt_reg;
    logic have_prev_reg, enabled_reg;
    logic accept;
    op_t op;

    assign op = op_t'(operation);
    assign in_ready = (state_reg == S_IDLE) && !out_busy;
    assign accept = in_valid && in_ready;
    assign emit = accept && (op == OP_FINISH);

    always_comb
    begin
        cmd = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept && op == OP_QUERY) cmd.load_query = 1'b1;
                if (accept && op == OP_VERTEX)
                begin
                    if (new_edge)
                    begin
                        cmd.load_edge = 1'b1;
                        cmd.load_vertex = 1'b1;
                    end
                    else if (have_prev_reg && enabled_reg)
                        cmd.seg_start = 1'b1;
                    else if (have_prev_reg)
                        cmd.load_vertex = 1'b1;
                end
            end
            S_VEC:    cmd.div_start = 1'b1;
            S_DIVSET: ;
            S_DIV:    cmd.div_step = 1'b1;
            S_PROJ:   cmd.proj = 1'b1;
            S_PX:     cmd.dist_prep = 1'b1;
            S_SQD:    cmd.sqrt_start = 1'b1;
            S_SQDRUN:
            begin
                cmd.sqrt_step = 1'b1;
            end
            S_SQS:
            begin
                cmd.sqrt_to_dist = 1'b1;
                cmd.sqrt_start = 1'b1;
            end
            S_SQSRUN: cmd.sqrt_step = 1'b1;
            S_ALONG:
            begin
                cmd.sqrt_to_seg = 1'b1;
            end
            S_ALMUL:  cmd.along_mul = 1'b1;
            S_COMMIT: cmd.commit = 1'b1;
            default: ;
        endcase
        if (state_reg == S_COMMIT) cmd.load_vertex = 1'b0;
    end

    // sequencer state and edge flags: the datapath takes x,y only at request time
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cnt_reg <= '0;
            have_prev_reg <= 1'b0;
            enabled_reg <= 1'b0;
        end
        else
        begin
            unique case (state_reg)
                S_IDLE:
                begin
                    if (accept && op == OP_QUERY)
                    begin
                        have_prev_reg <= 1'b0;
                        enabled_reg <= 1'b0;
                    end
                    if (accept && op == OP_VERTEX && new_edge)
                    begin
                        have_prev_reg <= 1'b1;
                        enabled_reg <= edge_enabled;
                    end
                    if (cmd.seg_start) state_reg <= S_VEC;
                end
                S_VEC: state_reg <= S_DIVSET;
                S_DIVSET:
                begin
                    cnt_reg <= 6'd30;
                    state_reg <= stat.seg_skip_div ? S_PROJ : S_DIV;
                end
                S_DIV:
                begin
                    cnt_reg <= cnt_reg - 6'd1;
                    if (cnt_reg == 6'd1) state_reg <= S_PROJ;
                end
                S_PROJ: state_reg <= S_PX;
                S_PX: state_reg <= S_SQD;
                S_SQD:
                begin
                    cnt_reg <= 6'd34;
                    state_reg <= S_SQDRUN;
                end
                S_SQDRUN:
                begin
                    cnt_reg <= cnt_reg - 6'd1;
                    if (cnt_reg == 6'd1) state_reg <= S_SQS;
                end
                S_SQS:
                begin
                    cnt_reg <= 6'd34;
                    state_reg <= S_SQSRUN;
                end
                S_SQSRUN:
                begin
                    cnt_reg <= cnt_reg - 6'd1;
                    if (cnt_reg == 6'd1) state_reg <= S_ALONG;
                end
                S_ALONG: state_reg <= S_ALMUL;
                S_ALMUL: state_reg <= S_COMMIT;
                S_COMMIT: state_reg <= S_IDLE;
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n) accept |-> state_reg == S_IDLE)
        else $error("request taken while busy");
    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_COMMIT |=> state_reg == S_IDLE)
        else $error("commit did not return to idle");
    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_DIV |-> cnt_reg != 6'd0)
        else $error("divider count underflow");

endmodule
`default_nettype wire

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the nearest polyline edge match
// Streams queries, edge polylines and finish requests through the valid/ready
// channels and compares every match result with an in-bench computation of
// the nearest segment projection, including clamping, ties and saturation.
// ----------------------------------------------------------------------------
module tb_top;
    import npem_pkg::*;

    typedef struct {
        op_t         op;
        logic [31:0] x;
        logic [31:0] y;
        logic        new_edge;
        logic        enabled;
        logic [15:0] ident;
        logic [15:0] from_node;
        logic [15:0] to_node;
        logic [31:0] length;
    } req_item_t;

    typedef struct {
        logic        found;
        logic [15:0] edge_id;
        logic [15:0] from_node;
        logic [15:0] to_node;
        logic [31:0] px;
        logic [31:0] py;
        logic [31:0] match_dist;
        logic [31:0] along;
        logic [31:0] length;
    } match_t;

    localparam int       SETTLE_CYCLES = 200;
    localparam int       HOLD_CYCLES   = 400;
    localparam logic [63:0] T_UNIT     = 64'd1 << T_FRAC;
    localparam logic [63:0] ALL32      = 64'hFFFF_FFFF;

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [31:0] cfg_data;

    npem_in_if  req_if ();
    npem_out_if res_if ();

    nearest_polyline_edge_match_top dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .req      (req_if.sink),
        .res      (res_if.source),
        .cfg_we   (cfg_we),
        .cfg_data (cfg_data)
    );

    // matcher state mirrored by the bench
    logic [31:0]        lim_dist;
    logic signed [63:0] qry_x, qry_y, prv_x, prv_y;
    logic               prv_ok;
    logic               edg_en;
    logic [15:0]        edg_id, edg_from, edg_to;
    logic [31:0]        edg_len;
    logic [63:0]        run_along;
    logic               best_ok;
    logic [63:0]        best_dist;
    match_t             best_rec;

    match_t pending_matches[$];
    int     fails;
    bit     no_gaps;
    int     hold_reqs;
    int     items_sent;

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    initial
    begin
        #2000000;
        $display("== FAIL ==");
        $finish;
    end

    function automatic logic [127:0] magnitude(input logic signed [63:0] v);
        magnitude = v < 0 ? 128'(-v) : 128'(v);
    endfunction

    function automatic logic [63:0] root_floor(input logic [127:0] n);
        logic [63:0]  r;
        logic [127:0] c;
        r = 0;
        for (int i = 33; i >= 0; i--)
        begin
            c = 128'(r | (64'd1 << i));
            if (c * c <= n)
                r = c[63:0];
        end
        root_floor = r;
    endfunction

    function automatic logic [63:0] sat_len(input logic [63:0] v);
        sat_len = v > ALL32 ? ALL32 : v;
    endfunction

    function automatic logic signed [63:0] step_toward(input logic [63:0] t,
                                                       input logic signed [63:0] v);
        logic [127:0] m;
        m = (128'(t) * magnitude(v)) >> T_FRAC;
        step_toward = v < 0 ? -$signed(m[63:0]) : $signed(m[63:0]);
    endfunction

    task automatic project_segment(input logic signed [63:0] bx, input logic signed [63:0] by);
        logic signed [63:0] vx, vy, wx, wy, px, py;
        logic [127:0] vv, pos, neg, dot, pr;
        logic [63:0]  t, d, seg, along;
        vx = bx - prv_x;
        vy = by - prv_y;
        wx = qry_x - prv_x;
        wy = qry_y - prv_y;
        vv = magnitude(vx) * magnitude(vx) + magnitude(vy) * magnitude(vy);
        pos = 0;
        neg = 0;
        pr = magnitude(wx) * magnitude(vx);
        if ((wx < 0) != (vx < 0)) neg += pr; else pos += pr;
        pr = magnitude(wy) * magnitude(vy);
        if ((wy < 0) != (vy < 0)) neg += pr; else pos += pr;
        t = 0;
        if (vv > 0 && pos > neg)
        begin
            dot = pos - neg;
            if (dot >= vv)
                t = T_UNIT;
            else
                t = 64'((dot << T_FRAC) / vv);
        end
        px = prv_x + step_toward(t, vx);
        py = prv_y + step_toward(t, vy);
        d = sat_len(root_floor(magnitude(px - qry_x) * magnitude(px - qry_x)
                               + magnitude(py - qry_y) * magnitude(py - qry_y)));
        seg = sat_len(root_floor(vv));
        along = sat_len(run_along + 64'((128'(t) * 128'(seg)) >> T_FRAC));
        if (!best_ok || d < best_dist)
        begin
            best_ok = 1'b1;
            best_dist = d;
            best_rec.edge_id = edg_id;
            best_rec.from_node = edg_from;
            best_rec.to_node = edg_to;
            best_rec.px = px[31:0];
            best_rec.py = py[31:0];
            best_rec.along = along[31:0];
            best_rec.length = edg_len;
        end
        run_along = sat_len(run_along + seg);
    endtask

    task automatic clear_search();
        prv_ok = 1'b0;
        edg_en = 1'b0;
        edg_id = 0;
        edg_from = 0;
        edg_to = 0;
        edg_len = 0;
        run_along = 0;
        best_ok = 1'b0;
        best_dist = ALL32;
        best_rec = '{default: '0};
    endtask

    // advance the mirrored state by one accepted request
    task automatic predict_match(input req_item_t it);
        match_t m;
        case (it.op)
            OP_QUERY:
            begin
                qry_x = $signed(it.x);
                qry_y = $signed(it.y);
                clear_search();
            end
            OP_VERTEX:
            begin
                if (it.new_edge)
                begin
                    edg_en = it.enabled;
                    edg_id = it.ident;
                    edg_from = it.from_node;
                    edg_to = it.to_node;
                    edg_len = it.length;
                    run_along = 0;
                    prv_ok = 1'b1;
                    prv_x = $signed(it.x);
                    prv_y = $signed(it.y);
                end
                else if (prv_ok)
                begin
                    if (edg_en)
                        project_segment($signed(it.x), $signed(it.y));
                    prv_x = $signed(it.x);
                    prv_y = $signed(it.y);
                end
            end
            OP_FINISH:
            begin
                m = '{default: '0};
                if (best_ok && best_dist <= 64'(lim_dist))
                begin
                    m = best_rec;
                    m.found = 1'b1;
                    m.match_dist = best_dist[31:0];
                end
                pending_matches.push_back(m);
            end
            default: ;
        endcase
    endtask

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (no_gaps || r < 60)
            pick_gap = 0;
        else if (r < 92)
            pick_gap = $urandom_range(1, 3);
        else
            pick_gap = $urandom_range(10, 40);
    endfunction

    task automatic send_req(input req_item_t it);
        int gap;
        gap = pick_gap();
        @(negedge clk);
        if (gap > 0)
        begin
            req_if.valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        req_if.operation = it.op;
        req_if.x = it.x;
        req_if.y = it.y;
        req_if.new_edge = it.new_edge;
        req_if.edge_enabled = it.enabled;
        req_if.edge_ident = it.ident;
        req_if.from_node = it.from_node;
        req_if.to_node = it.to_node;
        req_if.total_length = it.length;
        req_if.valid = 1'b1;
        do
            @(posedge clk);
        while (!req_if.ready);
        predict_match(it);
        items_sent++;
    endtask

    task automatic send_query(input logic [31:0] x, input logic [31:0] y);
        send_req('{OP_QUERY, x, y, 1'b0, 1'b0, 16'd0, 16'd0, 16'd0, 32'd0});
    endtask

    task automatic send_head(input logic [31:0] x, input logic [31:0] y, input logic en,
                             input logic [15:0] id, input logic [31:0] len);
        send_req('{OP_VERTEX, x, y, 1'b1, en, id, ~id, id ^ 16'h5A5A, len});
    endtask

    task automatic send_vertex(input logic [31:0] x, input logic [31:0] y);
        send_req('{OP_VERTEX, x, y, 1'b0, 1'b0, 16'd0, 16'd0, 16'd0, 32'd0});
    endtask

    task automatic send_finish();
        send_req('{OP_FINISH, 32'd0, 32'd0, 1'b0, 1'b0, 16'd0, 16'd0, 16'd0, 32'd0});
    endtask

    task automatic drain_results();
        @(negedge clk);
        req_if.valid = 1'b0;
        wait (pending_matches.size() == 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_limit(input logic [31:0] v);
        @(negedge clk);
        cfg_we = 1'b1;
        cfg_data = v;
        @(negedge clk);
        cfg_we = 1'b0;
        lim_dist = v;
    endtask

    function automatic logic [31:0] rand_coord();
        case ($urandom_range(0, 9))
            0: rand_coord = $urandom;
            1: rand_coord = $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
            default: rand_coord = 32'($signed($urandom_range(0, 32'h0040_0000)) - 32'sh20_0000);
        endcase
    endfunction

    // response side: random stalls, plus a long hold-off when asked
    initial
    begin
        int stall;
        int holds_seen;
        stall = 0;
        holds_seen = 0;
        res_if.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_reqs != holds_seen)
            begin
                holds_seen = hold_reqs;
                stall = HOLD_CYCLES;
            end
            if (stall > 0)
            begin
                stall--;
                res_if.ready = 1'b0;
            end
            else
            begin
                res_if.ready = 1'b1;
                stall = pick_gap();
            end
        end
    end

    always @(posedge clk)
    begin
        match_t e;
        if (rst_n && res_if.valid && res_if.ready)
        begin
            if (pending_matches.size() == 0)
            begin
                $error("unexpected result");
                fails++;
            end
            else
            begin
                e = pending_matches.pop_front();
                if (res_if.found !== e.found)
                begin
                    $error("found exp %0h got %0h", e.found, res_if.found); fails++;
                end
                if (res_if.match_edge !== e.edge_id)
                begin
                    $error("match_edge exp %0h got %0h", e.edge_id, res_if.match_edge); fails++;
                end
                if (res_if.match_from !== e.from_node)
                begin
                    $error("match_from exp %0h got %0h", e.from_node, res_if.match_from); fails++;
                end
                if (res_if.match_to !== e.to_node)
                begin
                    $error("match_to exp %0h got %0h", e.to_node, res_if.match_to); fails++;
                end
                if (res_if.proj_x !== e.px)
                begin
                    $error("proj_x exp %0h got %0h", e.px, res_if.proj_x); fails++;
                end
                if (res_if.proj_y !== e.py)
                begin
                    $error("proj_y exp %0h got %0h", e.py, res_if.proj_y); fails++;
                end
                if (res_if.match_distance !== e.match_dist)
                begin
                    $error("match_distance exp %0h got %0h", e.match_dist,
                           res_if.match_distance);
                    fails++;
                end
                if (res_if.along_edge !== e.along)
                begin
                    $error("along_edge exp %0h got %0h", e.along, res_if.along_edge); fails++;
                end
                if (res_if.match_length !== e.length)
                begin
                    $error("match_length exp %0h got %0h", e.length, res_if.match_length);
                    fails++;
                end
            end
        end
    end

    task automatic test_directed();
        send_finish();                              // nothing matched since reset
        send_vertex(32'd100, 32'd100);              // no open edge yet
        send_req('{OP_NONE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 1'b1, 16'hFFFF, 16'hFFFF,
                   16'hFFFF, 32'hFFFF_FFFF});
        send_finish();
        send_query(32'h0001_0000, 32'h0001_0000);
        send_vertex(32'd5, 32'd5);                  // orphan after query
        send_head(32'd0, 32'd0, 1'b1, 16'hFFFF, 32'hFFFF_FFFF);
        send_vertex(32'd0, 32'd0);                  // zero length segment
        send_vertex(32'h0002_0000, 32'd0);          // inner projection
        send_vertex(32'h0004_0000, 32'h0002_0000);
        send_head(32'd0, 32'd0, 1'b1, 16'h0001, 32'd0);
        send_vertex(32'h0002_0000, 32'd0);          // same segment again: tie keeps first
        send_head(32'h0001_0000, 32'h0001_0000, 1'b0, 16'h0002, 32'd7);
        send_vertex(32'h0001_0001, 32'h0001_0000);  // disabled edge right on the point
        send_finish();
        send_finish();                              // repeated finish
        send_query(32'h7FFF_FFFF, 32'h8000_0000);
        send_head(32'h8000_0000, 32'h8000_0000, 1'b1, 16'h0000, 32'd0);
        send_vertex(32'h7FFF_FFFF, 32'h7FFF_FFFF);
        send_vertex(32'h8000_0000, 32'h7FFF_FFFF);  // clamps at both ends, saturating
        send_finish();
        drain_results();
        write_limit(32'd0);
        send_finish();                              // distance over the limit
        send_query(32'd0, 32'd0);
        send_head(32'd0, 32'd0, 1'b1, 16'h1234, 32'd9);
        send_vertex(32'd3, 32'd0);
        send_finish();                              // exact hit at the limit
        drain_results();
    endtask

    task automatic random_sequence();
        int n_edges, n_verts;
        send_query(rand_coord(), rand_coord());
        if ($urandom_range(0, 9) == 0)
            send_vertex(rand_coord(), rand_coord());
        n_edges = $urandom_range(1, 4);
        for (int e = 0; e < n_edges; e++)
        begin
            send_head(rand_coord(), rand_coord(), $urandom_range(0, 4) != 0,
                      16'($urandom), $urandom);
            n_verts = $urandom_range(1, 4);
            for (int v = 0; v < n_verts; v++)
                send_vertex(rand_coord(), rand_coord());
        end
        if ($urandom_range(0, 9) == 0)
            send_req('{OP_NONE, $urandom, $urandom, 1'($urandom), 1'($urandom),
                       16'($urandom), 16'($urandom), 16'($urandom), $urandom});
        send_finish();
        if ($urandom_range(0, 9) == 0)
            send_finish();
    endtask

    task automatic test_random();
        logic [31:0] limits[4];
        limits = '{32'hFFFF_FFFF, 32'h0010_0000, $urandom, 32'h0000_8000};
        for (int p = 0; p < 4; p++)
        begin
            write_limit(limits[p]);
            no_gaps = (p == 2);
            while (items_sent < 250 * (p + 1))
                random_sequence();
            drain_results();
        end
        no_gaps = 1'b0;
    endtask

    task automatic test_backpressure();
        write_limit(32'hFFFF_FFFF);
        hold_reqs++;
        for (int i = 0; i < 6; i++)
            random_sequence();
        drain_results();
    endtask

    initial
    begin
        fails = 0;
        no_gaps = 1'b0;
        hold_reqs = 0;
        items_sent = 0;
        lim_dist = 32'hFFFF_FFFF;
        qry_x = 0;
        qry_y = 0;
        prv_x = 0;
        prv_y = 0;
        clear_search();
        cfg_we = 1'b0;
        cfg_data = 32'd0;
        req_if.valid = 1'b0;
        req_if.operation = OP_QUERY;
        req_if.x = 0;
        req_if.y = 0;
        req_if.new_edge = 1'b0;
        req_if.edge_enabled = 1'b0;
        req_if.edge_ident = 0;
        req_if.from_node = 0;
        req_if.to_node = 0;
        req_if.total_length = 0;
        rst_n = 1'b0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        test_directed();
        test_random();
        test_backpressure();
        if (fails == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end
endmodule
